/* design/fr90_pkg.sv */
// shared types and constants of the 90 degree frame rotator
`default_nettype none

package fr90_pkg;

    localparam int unsigned CH_W  = 16;
    localparam int unsigned PIX_W = 3 * CH_W;
    localparam int unsigned DIM_CFG_W = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_DIR = 2'd2;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    typedef struct packed {
        logic mem_write;
        logic mem_read;
        logic eol;
        logic eof;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* design/fr90_if.sv */
// stream interfaces for source pixels in and rotated pixels out
`default_nettype none

interface fr90_in_if;
    import fr90_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output kind, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input kind, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

interface fr90_out_if;
    import fr90_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            end_of_line;
    logic            end_of_frame;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output end_of_line, output end_of_frame, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input end_of_line, input end_of_frame, output ready);
endinterface

`default_nettype wire

/* design/fr90_ctrl.sv */
// controller: configuration, load and fetch counters, handshake sequencing
`default_nettype none

module fr90_ctrl #(
    parameter int unsigned MAX_DIM = 64,
    parameter int unsigned IDX_W   = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fr90_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fr90_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_kind,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2*IDX_W-1:0]                 mem_addr,
    output fr90_pkg::dp_cmd_t                  cmd
);
    import fr90_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned EXT_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PEND = 1'b1;

    logic                 state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIM_CFG_W-1:0] num_rows_reg, num_cols_reg;
    logic                 rotate_dir_reg;
    logic [IDX_W-1:0]     load_row_reg, load_row_next;
    logic [IDX_W-1:0]     load_col_reg, load_col_next;
    logic [IDX_W-1:0]     emit_row_reg, emit_row_next;
    logic [IDX_W-1:0]     emit_col_reg, emit_col_next;

    logic [DIM_W-1:0] nr_eff, nc_eff;
    logic [IDX_W-1:0] nr_last, nc_last;
    logic [IDX_W-1:0] src_row, src_col;
    logic             move, accept, eol, eof, dim_write;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
        logic [EXT_W-1:0] v_ext;
        v_ext = EXT_W'(v);
        if (v_ext == '0)
            eff_dim = DIM_W'(1);
        else if (v_ext > MAX_EXT)
            eff_dim = DIM_W'(MAX_DIM);
        else
            eff_dim = DIM_W'(v_ext);
    endfunction

    assign nr_eff  = eff_dim(num_rows_reg);
    assign nc_eff  = eff_dim(num_cols_reg);
    assign nr_last = IDX_W'(nr_eff - DIM_W'(1));
    assign nc_last = IDX_W'(nc_eff - DIM_W'(1));

    // handshake
    assign move      = (state_reg == ST_PEND) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == ST_IDLE) || move;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign dim_write = cfg_we && ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS));

    // rotated source coordinates
    always_comb
    begin
        if (rotate_dir_reg == DIR_LEFT)
        begin
            src_row = emit_col_reg;
            src_col = nc_last - emit_row_reg;
        end
        else
        begin
            src_row = nr_last - emit_col_reg;
            src_col = emit_row_reg;
        end
    end

    assign eol = (emit_col_reg == nr_last);
    assign eof = eol && (emit_row_reg == nc_last);

    assign mem_addr = (in_kind == KIND_LOAD) ? {load_row_reg, load_col_reg}
                                             : {src_row, src_col};

    always_comb
    begin
        cmd.mem_write = accept && (in_kind == KIND_LOAD);
        cmd.mem_read  = accept && (in_kind == KIND_FETCH);
        cmd.eol       = eol;
        cmd.eof       = eof;
        cmd.out_load  = move;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.mem_read)
                    state_next = ST_PEND;
            end
            ST_PEND:
            begin
                if (move && !cmd.mem_read)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // counters
    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        if (cmd.mem_write)
        begin
            if (load_col_reg == nc_last)
            begin
                load_col_next = '0;
                load_row_next = (load_row_reg == nr_last) ? '0 : load_row_reg + 1'b1;
            end
            else
            begin
                load_col_next = load_col_reg + 1'b1;
            end
        end
        if (cmd.mem_read)
        begin
            if (eol)
            begin
                emit_col_next = '0;
                emit_row_next = eof ? '0 : emit_row_reg + 1'b1;
            end
            else
            begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end
        if (dim_write)
        begin
            load_row_next = '0;
            load_col_next = '0;
            emit_row_next = '0;
            emit_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            num_rows_reg   <= DIM_RESET;
            num_cols_reg   <= DIM_RESET;
            rotate_dir_reg <= DIR_LEFT;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            emit_row_reg   <= '0;
            emit_col_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            emit_row_reg  <= emit_row_next;
            emit_col_reg  <= emit_col_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_ROWS:   num_rows_reg   <= cfg_data[DIM_CFG_W-1:0];
                    REG_NUM_COLS:   num_cols_reg   <= cfg_data[DIM_CFG_W-1:0];
                    REG_ROTATE_DIR: rotate_dir_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* design/fr90_dpath.sv */
// datapath: frame memory, read data register and output register
`default_nettype none

module fr90_dpath #(
    parameter int unsigned IDX_W = 6
) (
    input  wire logic                     clk,
    input  wire fr90_pkg::dp_cmd_t        cmd,
    input  wire logic [2*IDX_W-1:0]       mem_addr,
    input  wire logic [fr90_pkg::CH_W-1:0] in_red,
    input  wire logic [fr90_pkg::CH_W-1:0] in_green,
    input  wire logic [fr90_pkg::CH_W-1:0] in_blue,
    output logic [fr90_pkg::CH_W-1:0]     out_red,
    output logic [fr90_pkg::CH_W-1:0]     out_green,
    output logic [fr90_pkg::CH_W-1:0]     out_blue,
    output logic                          end_of_line,
    output logic                          end_of_frame
);
    import fr90_pkg::*;

    localparam int unsigned DEPTH = 1 << (2 * IDX_W);

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic             rd_eol_reg, rd_eof_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             eol_reg, eof_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            frame_mem[mem_addr] <= {in_red, in_green, in_blue};
        if (cmd.mem_read)
            rdata_reg <= frame_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_eol_reg <= cmd.eol;
            rd_eof_reg <= cmd.eof;
        end
        if (cmd.out_load)
        begin
            pix_reg <= rdata_reg;
            eol_reg <= rd_eol_reg;
            eof_reg <= rd_eof_reg;
        end
    end

    assign out_red      = pix_reg[3*CH_W-1:2*CH_W];
    assign out_green    = pix_reg[2*CH_W-1:CH_W];
    assign out_blue     = pix_reg[CH_W-1:0];
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule

`default_nettype wire

/* design/frame_rotate_90.sv */
// top level of the 90 degree frame rotator
//
//   channel   dir   carries
//   in_ch     in    kind, in_red, in_green, in_blue
//   out_ch    out   out_red, out_green, out_blue, end_of_line, end_of_frame
//   cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// one transaction per cycle on in_ch while out_ch keeps up
// a fetch reaches out_ch through the memory read data register, then the output register
// a fetch waiting on a full output register holds in_ch ready low until it moves on
// loads give no result; the frame memory has no reset, counters and config reset
`default_nettype none

module frame_rotate_90 #(
    parameter int unsigned MAX_DIM = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    fr90_in_if.sink                             in_ch,
    fr90_out_if.source                          out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [fr90_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fr90_pkg::CFG_DAT_W-1:0] cfg_data
);
    import fr90_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_DIM);

    dp_cmd_t            cmd;
    logic [2*IDX_W-1:0] mem_addr;

    fr90_ctrl #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_ch.valid),
        .in_kind   (in_ch.kind),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .mem_addr  (mem_addr),
        .cmd       (cmd)
    );

    fr90_dpath #(
        .IDX_W (IDX_W)
    ) u_dpath (
        .clk          (clk),
        .cmd          (cmd),
        .mem_addr     (mem_addr),
        .in_red       (in_ch.in_red),
        .in_green     (in_ch.in_green),
        .in_blue      (in_ch.in_blue),
        .out_red      (out_ch.out_red),
        .out_green    (out_ch.out_green),
        .out_blue     (out_ch.out_blue),
        .end_of_line  (out_ch.end_of_line),
        .end_of_frame (out_ch.end_of_frame)
    );

`ifndef SYNTH
    a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mem_read, cmd.mem_write}))
        else $error("memory read and write commanded together");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_read |=> (!cmd.mem_read || cmd.out_load))
        else $error("fetch issued over an unmoved read");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_ch.valid)
        else $error("output register loaded but not valid");
`endif

endmodule

`default_nettype wire
